// File: rtl/bpt_pkg.sv
// Shared types and constants for the bone palette table.
package bpt_pkg;

	// Operation codes carried on the kind field
	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_FIT    = 2'd3
	} kind_t;

	// Fixed field widths of the transaction ports
	localparam int CAP_W     = 8;
	localparam int SLOT_W    = 7;
	localparam int ID_PORT_W = 16;
	localparam int ACC_W     = 16;
	localparam int FS_W      = 9;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;
	localparam int               FS_MIN    = -(2 ** (FS_W - 1));

	// Control from the lookup stage to the fit accumulators
	typedef struct packed {
		logic clear;
		logic fit;
		logic hit;
		logic last;
	} fit_ctl_t;

endpackage

// File: rtl/bpt_cam.sv
// Palette storage with a parallel compare of one key against every filled slot.
module bpt_cam import bpt_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int ID_W  = 16,
	parameter int IDX_W = 7,
	parameter int CNT_W = 8
) (
	input  logic             clk,
	input  logic [ID_W-1:0]  key,
	input  logic [CNT_W-1:0] count,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	output logic             hit,
	output logic [IDX_W-1:0] hit_idx
);

	logic [ID_W-1:0]  ids_q [DEPTH];
	logic [DEPTH-1:0] match;

	// Write the new id into the next free slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ids_q[wr_idx] <= key;
		end
	end

	// Compare against filled slots only
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (ids_q[i] == key) && (CNT_W'(i) < count);
		end
	end

	// Stored ids are distinct, so at most one match: OR-encode its index
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
		hit = |match;
	end

endmodule

// File: rtl/bpt_fit_acc.sv
// Saturating fit-query counters for ids present and ids that would be new.
module bpt_fit_acc import bpt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  fit_ctl_t         ctl,
	output logic [ACC_W-1:0] common_count,
	output logic [ACC_W-1:0] additional_count
);

	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	logic [ACC_W-1:0] common_q;
	logic [ACC_W-1:0] additional_q;

	// Form the counts reported with this transaction
	always_comb begin
		common_count     = common_q;
		additional_count = additional_q;
		if (ctl.clear) begin
			common_count     = '0;
			additional_count = '0;
		end else if (ctl.fit) begin
			if (ctl.hit && common_q != ACC_MAX) begin
				common_count = common_q + 1'b1;
			end
			if (!ctl.hit && additional_q != ACC_MAX) begin
				additional_count = additional_q + 1'b1;
			end
		end
	end

	// Hold the counts; drop them at the end of a fit run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			common_q     <= '0;
			additional_q <= '0;
		end else if (en) begin
			if (ctl.fit && ctl.last) begin
				common_q     <= '0;
				additional_q <= '0;
			end else begin
				common_q     <= common_count;
				additional_q <= additional_count;
			end
		end
	end

endmodule

// File: rtl/bone_palette_table.sv
// Top level of the bone palette table.
// A transaction passes through the input register, then the result register, where
// its result is held until it is taken.
// Throughput: one transaction per cycle unless the result side stalls; the parallel
// compare and the palette update both finish between the two registers.
// Reset: palette empty, fit counts zero, capacity 128; slot contents kept.
module bone_palette_table import bpt_pkg::*; #(
	parameter int PALETTE_DEPTH = 128,
	parameter int BONE_ID_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CAP_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              kind,
	input  logic [ID_PORT_W-1:0]    bone_id,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found,
	output logic [SLOT_W-1:0]       slot,
	output logic                    full_res,
	output logic [ACC_W-1:0]        common_count,
	output logic [ACC_W-1:0]        additional_count,
	output logic signed [FS_W-1:0]  free_space
);

	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int FSC_W = CMP_W + 1;

	logic [CAP_W-1:0]     cap_q;
	logic [CNT_W-1:0]     count_q;

	logic                 valid_s1;
	kind_t                kind_s1;
	logic [BONE_ID_BITS-1:0] id_s1;
	logic                 last_s1;

	logic                 valid_s2;
	logic                 found_s2;
	logic [SLOT_W-1:0]    slot_s2;
	logic                 full_s2;
	logic [ACC_W-1:0]     common_s2;
	logic [ACC_W-1:0]     additional_s2;
	logic [FS_W-1:0]      free_s2;

	logic                 advance;
	logic                 hit;
	logic [IDX_W-1:0]     hit_idx;
	logic                 wr_en;
	logic                 at_limit;
	logic                 found_c;
	logic [SLOT_W-1:0]    slot_c;
	logic                 full_c;
	logic [CNT_W-1:0]     count_nxt;
	logic signed [FSC_W-1:0] fs_full;
	logic [FS_W-1:0]      free_c;
	logic [ACC_W-1:0]     common_c;
	logic [ACC_W-1:0]     additional_c;
	fit_ctl_t             fit_ctl;

	// Handshake: the stage-1 transaction moves on whenever the result register frees
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind_t'(kind);
			id_s1   <= BONE_ID_BITS'(bone_id);
			last_s1 <= last;
		end
	end

	bpt_cam #(
		.DEPTH (PALETTE_DEPTH),
		.ID_W  (BONE_ID_BITS),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_cam (
		.clk     (clk),
		.key     (id_s1),
		.count   (count_q),
		.wr_en   (wr_en),
		.wr_idx  (count_q[IDX_W-1:0]),
		.hit     (hit),
		.hit_idx (hit_idx)
	);

	// Storage is full once the count reaches capacity or the slot count
	assign at_limit = (CMP_W'(count_q) >= CMP_W'(cap_q)) ||
		(CMP_W'(count_q) >= CMP_W'(PALETTE_DEPTH));

	// Decode the operation
	always_comb begin
		found_c   = 1'b0;
		slot_c    = '0;
		full_c    = 1'b0;
		wr_en     = 1'b0;
		count_nxt = count_q;
		case (kind_s1)
			KIND_CLEAR: begin
				count_nxt = '0;
			end
			KIND_ADD: begin
				if (hit) begin
					found_c = 1'b1;
					slot_c  = SLOT_W'(hit_idx);
				end else if (at_limit) begin
					full_c = 1'b1;
				end else begin
					slot_c    = SLOT_W'(count_q);
					wr_en     = advance;
					count_nxt = count_q + 1'b1;
				end
			end
			KIND_LOOKUP, KIND_FIT: begin
				found_c = hit;
				slot_c  = hit ? SLOT_W'(hit_idx) : '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	// Free space after this transaction, saturated at the low end
	always_comb begin
		fs_full = $signed({1'b0, CMP_W'(cap_q)}) - $signed({1'b0, CMP_W'(count_nxt)});
		if (fs_full < $signed(FSC_W'(FS_MIN))) begin
			free_c = FS_W'(FS_MIN);
		end else begin
			free_c = FS_W'(fs_full);
		end
	end

	assign fit_ctl.clear = (kind_s1 == KIND_CLEAR);
	assign fit_ctl.fit   = (kind_s1 == KIND_FIT);
	assign fit_ctl.hit   = hit;
	assign fit_ctl.last  = last_s1;

	bpt_fit_acc u_fit_acc (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (advance),
		.ctl              (fit_ctl),
		.common_count     (common_c),
		.additional_count (additional_c)
	);

	// Stored count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_s2      <= found_c;
			slot_s2       <= slot_c;
			full_s2       <= full_c;
			common_s2     <= common_c;
			additional_s2 <= additional_c;
			free_s2       <= free_c;
		end
	end

	assign out_valid        = valid_s2;
	assign found            = found_s2;
	assign slot             = slot_s2;
	assign full_res         = full_s2;
	assign common_count     = common_s2;
	assign additional_count = additional_s2;
	assign free_space       = $signed(free_s2);

endmodule

// File: rtl/bpt_checker.sv
// Port-level checks for the bone palette table, bound to the top level.
module bpt_checker import bpt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   found,
	input logic [SLOT_W-1:0]      slot,
	input logic                   full_res,
	input logic [ACC_W-1:0]       common_count,
	input logic [ACC_W-1:0]       additional_count,
	input logic signed [FS_W-1:0] free_space
);

	// Hold a stalled result transaction unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(slot) &&
		$stable(full_res) && $stable(common_count) && $stable(additional_count) &&
		$stable(free_space))
		else $error("result changed while stalled");

	// A refused add reports neither a hit nor a slot
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_res |-> !found && slot == '0)
		else $error("refused add reports a slot");

	// Input side never stalls unless the result side is blocked
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with free result register");

endmodule

bind bone_palette_table bpt_checker u_bpt_checker (.*);

// File: sim/bone_palette_table_check.sv
// Checker for the bone palette table: predicts each result and compares it on the output channel.
module bone_palette_table_check import bpt_pkg::*; #(
	parameter int PALETTE_DEPTH = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CAP_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [1:0]              kind,
	input  logic [ID_PORT_W-1:0]    bone_id,
	input  logic                    last,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic                    found,
	input  logic [SLOT_W-1:0]       slot,
	input  logic                    full_res,
	input  logic [ACC_W-1:0]        common_count,
	input  logic [ACC_W-1:0]        additional_count,
	input  logic signed [FS_W-1:0]  free_space,
	output int                      pending,
	output int                      mismatches
);

	typedef struct packed {
		logic                   found;
		logic [SLOT_W-1:0]      slot;
		logic                   full;
		logic [ACC_W-1:0]       common;
		logic [ACC_W-1:0]       additional;
		logic signed [FS_W-1:0] free;
	} palette_result_t;

	// Shadow copy of the palette, its counters and the capacity register
	logic [ID_PORT_W-1:0] palette_ids [PALETTE_DEPTH];
	int                   stored;
	logic [ACC_W-1:0]     common_acc;
	logic [ACC_W-1:0]     additional_acc;
	logic [CAP_W-1:0]     capacity;

	palette_result_t awaited_results [$];

	// Apply one transaction to the shadow palette and return the result it should give
	function automatic palette_result_t palette_apply(input kind_t op,
			input logic [ID_PORT_W-1:0] id, input logic closes);
		palette_result_t r;
		int              where;
		bit              hit;
		int              fs;
		int              usable;
		r = '0;
		where = 0;
		hit = 1'b0;
		usable = (capacity < PALETTE_DEPTH) ? int'(capacity) : PALETTE_DEPTH;
		for (int i = 0; i < stored; i++) begin
			if (!hit && palette_ids[i] == id) begin
				hit = 1'b1;
				where = i;
			end
		end
		case (op)
			KIND_CLEAR: begin
				stored = 0;
				common_acc = '0;
				additional_acc = '0;
			end
			KIND_ADD: begin
				if (hit) begin
					r.found = 1'b1;
					r.slot = where[SLOT_W-1:0];
				end else if (stored >= usable) begin
					r.full = 1'b1;
				end else begin
					r.slot = stored[SLOT_W-1:0];
					palette_ids[stored] = id;
					stored++;
				end
			end
			KIND_LOOKUP: begin
				r.found = hit;
				r.slot = hit ? where[SLOT_W-1:0] : '0;
			end
			default: begin
				r.found = hit;
				r.slot = hit ? where[SLOT_W-1:0] : '0;
				// Saturate the fit counts rather than wrap
				if (hit) begin
					if (common_acc != '1) common_acc++;
				end else begin
					if (additional_acc != '1) additional_acc++;
				end
			end
		endcase
		r.common = common_acc;
		r.additional = additional_acc;
		fs = int'(capacity) - stored;
		if (fs > 255) fs = 255;
		if (fs < -256) fs = -256;
		r.free = fs[FS_W-1:0];
		// A closing fit item reports the totals, then starts a fresh run
		if (op == KIND_FIT && closes) begin
			common_acc = '0;
			additional_acc = '0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
				$signed(want), $signed(got));
			mismatches++;
		end
	endtask

	// Track configuration and transactions on both channels
	always @(posedge clk or negedge arst_n) begin
		palette_result_t want;
		if (!arst_n) begin
			stored = 0;
			common_acc = '0;
			additional_acc = '0;
			capacity = CAP_RESET;
			awaited_results.delete();
			pending = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) capacity = cfg_wdata;
			// Retire the oldest expectation before queueing a new one
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result transaction with no expectation waiting", $time);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("found", 32'(want.found), 32'(found));
					check_field("slot", 32'(want.slot), 32'(slot));
					check_field("full_res", 32'(want.full), 32'(full_res));
					check_field("common_count", 32'(want.common), 32'(common_count));
					check_field("additional_count", 32'(want.additional),
						32'(additional_count));
					check_field("free_space", 32'($signed(want.free)),
						32'($signed(free_space)));
				end
			end
			if (in_valid && in_ready)
				awaited_results.insert(awaited_results.size(),
					palette_apply(kind_t'(kind), bone_id, last));
			pending = awaited_results.size();
		end
	end

endmodule

// File: sim/bone_palette_table_test.sv
// Testbench top for the bone palette table: clock, reset, stimulus and verdict.
module bone_palette_table_test import bpt_pkg::*;;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 300;
	localparam int PHASE_COUNT  = 6;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CAP_W-1:0]       cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [1:0]             kind = KIND_CLEAR;
	logic [ID_PORT_W-1:0]   bone_id = '0;
	logic                   last = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   found;
	logic [SLOT_W-1:0]      slot;
	logic                   full_res;
	logic [ACC_W-1:0]       common_count;
	logic [ACC_W-1:0]       additional_count;
	logic signed [FS_W-1:0] free_space;

	int pending;
	int mismatches;

	int               send_gap_pct = 0;
	int               ready_stall_pct = 0;
	logic             hold_on = 1'b0;
	int               hold_done = 0;
	int               cycle_count = 0;
	int               items_sent = 0;
	logic [ID_PORT_W-1:0] id_base = '0;

	bone_palette_table DUT (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.in_valid, .in_ready, .kind, .bone_id, .last,
		.out_valid, .out_ready, .found, .slot, .full_res,
		.common_count, .additional_count, .free_space
	);

	bone_palette_table_check palette_watch (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.in_valid, .in_ready, .kind, .bone_id, .last,
		.out_valid, .out_ready, .found, .slot, .full_res,
		.common_count, .additional_count, .free_space,
		.pending, .mismatches
	);

	always #4 clk = ~clk;

	// Stall the result channel: one long hold on request, otherwise at random
	always @(posedge clk) begin
		if (hold_on && hold_done < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_done <= hold_done + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one transaction, after an optional random gap, and hold it until taken
	task automatic send_item(input kind_t op, input logic [ID_PORT_W-1:0] id,
			input logic closes);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		bone_id <= id;
		last <= closes;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Drop valid and wait until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly ids from a small pool so that hits are common
	function automatic logic [ID_PORT_W-1:0] pick_id();
		if ($urandom_range(99) < 75)
			return id_base + ID_PORT_W'($urandom_range(0, 39));
		return ID_PORT_W'($urandom);
	endfunction

	task automatic random_transaction();
		int r;
		int run;
		r = $urandom_range(99);
		if (r < 3) begin
			send_item(KIND_CLEAR, ID_PORT_W'($urandom), 1'($urandom));
		end else if (r < 40) begin
			send_item(KIND_ADD, pick_id(), 1'($urandom));
		end else if (r < 65) begin
			send_item(KIND_LOOKUP, pick_id(), 1'($urandom));
		end else if (r < 95) begin
			// Well-formed fit run closed by last
			run = $urandom_range(1, 6);
			for (int j = 0; j < run; j++)
				send_item(KIND_FIT, pick_id(), j == run - 1);
		end else begin
			send_item(KIND_FIT, pick_id(), 1'($urandom));
		end
	endtask

	initial begin
		logic [CAP_W-1:0] phase_caps [PHASE_COUNT];
		int               phase_end;
		phase_caps = '{8'd128, 8'd12, 8'd255, 8'd1, 8'd0, 8'd64};
		phase_caps[4] = CAP_W'($urandom_range(2, 127));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of the ids, every kind, fit totals and clears
		send_item(KIND_LOOKUP, 16'h0000, 1'b0);
		send_item(KIND_FIT, 16'h0005, 1'b0);
		send_item(KIND_ADD, 16'h0000, 1'b0);
		send_item(KIND_ADD, 16'hFFFF, 1'b1);
		send_item(KIND_ADD, 16'h0000, 1'b0);
		send_item(KIND_LOOKUP, 16'hFFFF, 1'b1);
		send_item(KIND_LOOKUP, 16'h1234, 1'b0);
		send_item(KIND_FIT, 16'h0000, 1'b0);
		send_item(KIND_FIT, 16'hFFFF, 1'b0);
		send_item(KIND_FIT, 16'h0007, 1'b1);
		send_item(KIND_ADD, 16'h5555, 1'b0);
		send_item(KIND_ADD, 16'hAAAA, 1'b0);
		send_item(KIND_FIT, 16'h5555, 1'b0);
		send_item(KIND_CLEAR, 16'hFFFF, 1'b1);
		send_item(KIND_LOOKUP, 16'h0000, 1'b0);
		send_item(KIND_FIT, 16'hAAAA, 1'b1);
		settle();

		// Capacity of one: second add refused as full
		write_capacity(8'd1);
		send_item(KIND_ADD, 16'h0001, 1'b0);
		send_item(KIND_ADD, 16'h0002, 1'b0);
		send_item(KIND_ADD, 16'h0001, 1'b0);
		send_item(KIND_LOOKUP, 16'h0002, 1'b0);
		settle();

		// Capacity of zero with one entry stored: free space goes negative
		write_capacity(8'd0);
		send_item(KIND_ADD, 16'h0003, 1'b0);
		send_item(KIND_CLEAR, 16'h0000, 1'b0);
		send_item(KIND_ADD, 16'h0004, 1'b0);
		settle();

		write_capacity(8'd255);
		send_item(KIND_ADD, 16'h0004, 1'b0);
		settle();

		// Fill every slot and run past the end of storage
		write_capacity(8'd128);
		send_item(KIND_CLEAR, 16'h0000, 1'b0);
		for (int i = 0; i < 130; i++)
			send_item(KIND_ADD, 16'h1000 + ID_PORT_W'(i * 37), 1'($urandom));
		send_item(KIND_LOOKUP, 16'h1000 + ID_PORT_W'(127 * 37), 1'b0);
		settle();

		// Lower the capacity beneath the stored count
		write_capacity(8'd5);
		send_item(KIND_ADD, 16'h0BAD, 1'b0);
		send_item(KIND_LOOKUP, 16'h1000 + ID_PORT_W'(64 * 37), 1'b0);
		send_item(KIND_FIT, 16'h1000, 1'b0);
		send_item(KIND_FIT, 16'h0BAD, 1'b1);
		settle();

		// Random phases across capacities and idling patterns
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			write_capacity(phase_caps[phase]);
			id_base = ID_PORT_W'($urandom);
			case (phase % 4)
				0: begin
					send_gap_pct = 0;
					ready_stall_pct <= 0;
				end
				1: begin
					send_gap_pct = 52;
					ready_stall_pct <= 0;
				end
				2: begin
					send_gap_pct = 0;
					ready_stall_pct <= 52;
					hold_on <= 1'b1;
				end
				default: begin
					send_gap_pct = 27;
					ready_stall_pct <= 27;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				random_transaction();
				// Pause the sender mid-phase until the results have caught up
				if (phase == 1 && items_sent >= phase_end - PHASE_ITEMS / 2 &&
						items_sent < phase_end - PHASE_ITEMS / 2 + 6)
					settle();
			end
			settle();
		end

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
